[sv/complex_arithmetic_unit_defines.svh]
// ----------------------------------------------------------------------------
// complex arithmetic unit assertion macros
// check forms used by the complex_arithmetic_unit module
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// a implies b on the same clock edge
`define CAU_ASSERT_IMPLIES(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("cau check failed");

// expr never holds
`define CAU_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("cau check failed");

`endif

[sv/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// types, widths and helpers of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_W    = 16;
  localparam int FRAC_BITS = 8;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int VAL_W     = 2 * DATA_W + 1;
  localparam int QUO_W     = DATA_W + 1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_e;

  typedef struct packed {
    cau_op_e                   op;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
  } cau_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;
    logic                     overflow;
    logic                     div_by_zero;
  } cau_res_t;

  // one part after the front end
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic                    neg;
    logic [PROD_W-1:0]       mag;
  } cau_pre_part_t;

  typedef struct packed {
    logic              valid;
    cau_op_e           op;
    logic              dz;
    logic [PROD_W-1:0] den;
    cau_pre_part_t     re;
    cau_pre_part_t     im;
  } cau_pre_t;

  // one part inside the divider
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic                    neg;
    logic                    pre_ovf;
    logic [PROD_W-1:0]       rem;
    logic [QUO_W-1:0]        n_lo;
    logic [QUO_W-1:0]        quo;
  } cau_div_part_t;

  typedef struct packed {
    logic              valid;
    cau_op_e           op;
    logic              dz;
    logic [PROD_W-1:0] den;
    cau_div_part_t     re;
    cau_div_part_t     im;
  } cau_div_t;

  localparam logic signed [VAL_W-1:0] SAT_HI =
    {{(VAL_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SAT_LO = ~SAT_HI;

  // returns {overflow, clamped value}
  function automatic logic [DATA_W:0] cau_sat(input logic signed [VAL_W-1:0] v);
    logic [DATA_W:0] r;
    if (v > SAT_HI) begin
      r = {1'b1, SAT_HI[DATA_W-1:0]};
    end else if (v < SAT_LO) begin
      r = {1'b1, SAT_LO[DATA_W-1:0]};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

endpackage

[sv/cau_front.sv]
// ----------------------------------------------------------------------------
// cau_front
// input register, product stage and sum stage of the complex arithmetic unit
// ----------------------------------------------------------------------------
module cau_front #(
  parameter int FracBits = cau_pkg::FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cau_pkg::cau_req_t req_i,
  output cau_pkg::cau_pre_t pre_o
);
  import cau_pkg::*;

  logic     s1_valid_q;
  cau_req_t s1_q;

  logic                     s2_valid_q;
  cau_op_e                  s2_op_q;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic [PROD_W-1:0]        sq_r_q, sq_i_q;
  logic signed [VAL_W-1:0]  as_re_q, as_im_q;
  logic signed [VAL_W-1:0]  as_re_d, as_im_d;

  cau_pre_t                 pre_q, pre_d;
  logic signed [VAL_W-1:0]  mul_re, mul_im, num_re, num_im;
  logic [PROD_W-1:0]        den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      pre_q.valid <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      pre_q      <= pre_d;
    end
  end

  // stage two: products and add/sub
  always_comb begin
    if (s1_q.op == OP_SUB) begin
      as_re_d = VAL_W'(s1_q.a_re) - VAL_W'(s1_q.b_re);
      as_im_d = VAL_W'(s1_q.a_im) - VAL_W'(s1_q.b_im);
    end else begin
      as_re_d = VAL_W'(s1_q.a_re) + VAL_W'(s1_q.b_re);
      as_im_d = VAL_W'(s1_q.a_im) + VAL_W'(s1_q.b_im);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q    <= req_i;
    s2_op_q <= s1_q.op;
    p_rr_q  <= s1_q.a_re * s1_q.b_re;
    p_ii_q  <= s1_q.a_im * s1_q.b_im;
    p_ri_q  <= s1_q.a_re * s1_q.b_im;
    p_ir_q  <= s1_q.a_im * s1_q.b_re;
    sq_r_q  <= s1_q.b_re * s1_q.b_re;
    sq_i_q  <= s1_q.b_im * s1_q.b_im;
    as_re_q <= as_re_d;
    as_im_q <= as_im_d;
  end

  // stage three: sums, shifts, divide numerators and denominator
  always_comb begin
    mul_re = (VAL_W'(p_rr_q) - VAL_W'(p_ii_q)) >>> FracBits;
    mul_im = (VAL_W'(p_ri_q) + VAL_W'(p_ir_q)) >>> FracBits;
    num_re = VAL_W'(p_rr_q) + VAL_W'(p_ii_q);
    num_im = VAL_W'(p_ir_q) - VAL_W'(p_ri_q);
    den    = sq_r_q + sq_i_q;

    pre_d.valid = s2_valid_q;
    pre_d.op    = s2_op_q;
    pre_d.den   = den;
    pre_d.dz    = (s2_op_q == OP_DIV) && (den == '0);
    pre_d.re.neg = num_re[VAL_W-1];
    pre_d.im.neg = num_im[VAL_W-1];
    pre_d.re.mag = num_re[VAL_W-1] ? PROD_W'(-num_re) : PROD_W'(num_re);
    pre_d.im.mag = num_im[VAL_W-1] ? PROD_W'(-num_im) : PROD_W'(num_im);

    case (s2_op_q)
      OP_ADD, OP_SUB: begin
        pre_d.re.val = as_re_q;
        pre_d.im.val = as_im_q;
      end
      OP_MUL: begin
        pre_d.re.val = mul_re;
        pre_d.im.val = mul_im;
      end
      default: begin
        pre_d.re.val = '0;
        pre_d.im.val = '0;
      end
    endcase
  end

  assign pre_o = pre_q;

endmodule

[sv/cau_div_step.sv]
// ----------------------------------------------------------------------------
// cau_div_step
// one restoring division step for both parts, one quotient bit per stage
// ----------------------------------------------------------------------------
module cau_div_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cau_pkg::cau_div_t div_i,
  output cau_pkg::cau_div_t div_o
);
  import cau_pkg::*;

  cau_div_t          div_q, div_d;
  logic [PROD_W:0]   tr_re, tr_im;
  logic              ge_re, ge_im;

  always_comb begin
    div_d = div_i;
    tr_re = {div_i.re.rem, div_i.re.n_lo[QUO_W-1]};
    tr_im = {div_i.im.rem, div_i.im.n_lo[QUO_W-1]};
    ge_re = tr_re >= {1'b0, div_i.den};
    ge_im = tr_im >= {1'b0, div_i.den};
    div_d.re.rem  = ge_re ? PROD_W'(tr_re - {1'b0, div_i.den}) : PROD_W'(tr_re);
    div_d.im.rem  = ge_im ? PROD_W'(tr_im - {1'b0, div_i.den}) : PROD_W'(tr_im);
    div_d.re.n_lo = {div_i.re.n_lo[QUO_W-2:0], 1'b0};
    div_d.im.n_lo = {div_i.im.n_lo[QUO_W-2:0], 1'b0};
    div_d.re.quo  = {div_i.re.quo[QUO_W-2:0], ge_re};
    div_d.im.quo  = {div_i.im.quo[QUO_W-2:0], ge_im};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q.valid <= 1'b0;
    end else begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

[sv/complex_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// pipelined complex add, subtract, multiply and divide in signed fixed point
// ----------------------------------------------------------------------------
// channel   ports                    direction  handshake
// request   start_i, busy_o, req_i   in         start_i high, busy_o low
// result    valid_o, res_o           out        one-cycle strobe, no stall
//
// one request per cycle; every operation passes through the one-bit-per-stage
// divider chain
// busy_o stays low; results leave in request order
// reset clears only the stage valid bits
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int FracBits = cau_pkg::FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  cau_pkg::cau_req_t req_i,
  output logic              valid_o,
  output cau_pkg::cau_res_t res_o
);
  import cau_pkg::*;
  `include "complex_arithmetic_unit_defines.svh"

  localparam int NumW = PROD_W + FracBits;
  localparam int HiW  = NumW - QUO_W;
  localparam int CmpW = (HiW > PROD_W) ? HiW : PROD_W;
  localparam int Lat  = QUO_W + 5;

  cau_pre_t             pre;
  cau_div_t             chain [QUO_W+1];
  cau_div_t             ck_q, ck_d;
  logic [NumW-1:0]      n_re, n_im;
  logic [CmpW-1:0]      hi_re, hi_im, den_x;

  logic                 accept;
  logic                 out_valid_q;
  cau_res_t             res_q, res_d;
  logic signed [VAL_W-1:0] v_re, v_im;
  logic [DATA_W:0]      s_re, s_im;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  cau_front #(.FracBits(FracBits)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .req_i  (req_i),
    .pre_o  (pre)
  );

  // divider range check and set-up
  always_comb begin
    n_re  = {pre.re.mag, {FracBits{1'b0}}};
    n_im  = {pre.im.mag, {FracBits{1'b0}}};
    hi_re = CmpW'(n_re >> QUO_W);
    hi_im = CmpW'(n_im >> QUO_W);
    den_x = CmpW'(pre.den);

    ck_d.valid = pre.valid;
    ck_d.op    = pre.op;
    ck_d.dz    = pre.dz;
    ck_d.den   = pre.den;
    ck_d.re.val     = pre.re.val;
    ck_d.im.val     = pre.im.val;
    ck_d.re.neg     = pre.re.neg;
    ck_d.im.neg     = pre.im.neg;
    ck_d.re.pre_ovf = (pre.op == OP_DIV) && !pre.dz && (hi_re >= den_x);
    ck_d.im.pre_ovf = (pre.op == OP_DIV) && !pre.dz && (hi_im >= den_x);
    ck_d.re.rem     = hi_re[PROD_W-1:0];
    ck_d.im.rem     = hi_im[PROD_W-1:0];
    ck_d.re.n_lo    = n_re[QUO_W-1:0];
    ck_d.im.n_lo    = n_im[QUO_W-1:0];
    ck_d.re.quo     = '0;
    ck_d.im.quo     = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ck_q.valid  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ck_q        <= ck_d;
      out_valid_q <= chain[QUO_W].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign chain[0] = ck_q;

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    cau_div_step u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .div_i (chain[g]),
      .div_o (chain[g+1])
    );
  end

  // sign, saturation and flags
  always_comb begin
    v_re = chain[QUO_W].re.val;
    v_im = chain[QUO_W].im.val;
    if (chain[QUO_W].op == OP_DIV) begin
      v_re = chain[QUO_W].re.neg ? -VAL_W'(chain[QUO_W].re.quo)
                                 : VAL_W'(chain[QUO_W].re.quo);
      v_im = chain[QUO_W].im.neg ? -VAL_W'(chain[QUO_W].im.quo)
                                 : VAL_W'(chain[QUO_W].im.quo);
      if (chain[QUO_W].re.pre_ovf) begin
        v_re = chain[QUO_W].re.neg ? SAT_LO - 1 : SAT_HI + 1;
      end
      if (chain[QUO_W].im.pre_ovf) begin
        v_im = chain[QUO_W].im.neg ? SAT_LO - 1 : SAT_HI + 1;
      end
      if (chain[QUO_W].dz) begin
        v_re = '0;
        v_im = '0;
      end
    end
    s_re = cau_sat(v_re);
    s_im = cau_sat(v_im);
    res_d.res_re      = s_re[DATA_W-1:0];
    res_d.res_im      = s_im[DATA_W-1:0];
    res_d.overflow    = s_re[DATA_W] | s_im[DATA_W];
    res_d.div_by_zero = chain[QUO_W].dz;
  end

  assign valid_o = out_valid_q;
  assign res_o   = res_q;

  `CAU_ASSERT_NEVER(a_dz_and_ovf, valid_o && res_o.div_by_zero && res_o.overflow)
  `CAU_ASSERT_IMPLIES(a_dz_zero, valid_o && res_o.div_by_zero,
                      res_o.res_re == '0 && res_o.res_im == '0)
  `CAU_ASSERT_IMPLIES(a_latency, valid_o, $past(accept, Lat))

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// complex arithmetic unit testbench
// drives add, subtract, multiply and divide requests from a directed table and
// then at random, predicts each result in fixed point and checks it in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import cau_pkg::*;

  localparam int LATENCY     = DATA_W + 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM    = 530;

  typedef struct packed {
    cau_req_t req;
    logic     has_res;
    cau_res_t res;
  } vec_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start_i = 1'b0;
  logic     busy_o;
  cau_req_t req_i = '0;
  logic     valid_o;
  cau_res_t res_o;

  cau_res_t expected_q[$];
  int       errors = 0;
  int       cycles = 0;
  int       send_idle = 0;

  complex_arithmetic_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic signed [63:0] floor_shift(input logic signed [63:0] v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic logic signed [63:0] trunc_div(input logic signed [63:0] num,
                                                   input logic signed [63:0] den);
    logic signed [63:0] mag;
    logic signed [63:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FRAC_BITS) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic void clamp(input logic signed [63:0] v,
                                output logic signed [DATA_W-1:0] r, inout logic ovf);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (DATA_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      r = hi[DATA_W-1:0];
      ovf = 1'b1;
    end else if (v < lo) begin
      r = lo[DATA_W-1:0];
      ovf = 1'b1;
    end else begin
      r = v[DATA_W-1:0];
    end
  endfunction

  function automatic cau_res_t complex_result(input cau_req_t q);
    logic signed [63:0] ar, ai, br, bi, re, im, den;
    cau_res_t r;
    ar = q.a_re;
    ai = q.a_im;
    br = q.b_re;
    bi = q.b_im;
    re = 0;
    im = 0;
    r = '0;
    case (q.op)
      OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      OP_MUL: begin
        re = floor_shift(ar * br - ai * bi);
        im = floor_shift(ar * bi + ai * br);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          re = trunc_div(ar * br + ai * bi, den);
          im = trunc_div(ai * br - ar * bi, den);
        end
      end
    endcase
    clamp(re, r.res_re, r.overflow);
    clamp(im, r.res_im, r.overflow);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_part();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(DATA_W-1){1'b1}}};
      1: return {1'b1, {(DATA_W-1){1'b0}}};
      2: return '0;
      3: return DATA_W'($signed($urandom_range(0, 1023)) - 512);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic send(input cau_req_t q, input logic has_res, input cau_res_t r);
    cau_res_t predicted;
    while ($urandom_range(0, 99) < send_idle) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    predicted = complex_result(q);
    if (has_res && predicted != r) begin
      $display("%0t table row mismatch: expected %h actual %h", $time, r, predicted);
      errors++;
    end
    start_i <= 1'b1;
    req_i <= q;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_q.push_back(predicted);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_ni && valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, res_o);
        errors++;
      end else begin
        if (res_o.res_re !== expected_q[0].res_re)
          $display("%0t res_re expected %h actual %h", $time, expected_q[0].res_re,
                   res_o.res_re);
        if (res_o.res_im !== expected_q[0].res_im)
          $display("%0t res_im expected %h actual %h", $time, expected_q[0].res_im,
                   res_o.res_im);
        if (res_o.overflow !== expected_q[0].overflow)
          $display("%0t overflow expected %b actual %b", $time,
                   expected_q[0].overflow, res_o.overflow);
        if (res_o.div_by_zero !== expected_q[0].div_by_zero)
          $display("%0t div_by_zero expected %b actual %b", $time,
                   expected_q[0].div_by_zero, res_o.div_by_zero);
        if (res_o !== expected_q[0]) errors++;
        void'(expected_q.pop_front());
      end
    end
  end

  localparam logic signed [DATA_W-1:0] MAXV = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MINV = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] ONE  = DATA_W'(1 <<< FRAC_BITS);

  vec_t table_v[] = '{
    '{'{OP_ADD, 0, 0, 0, 0}, 1'b1, '{0, 0, 1'b0, 1'b0}},
    '{'{OP_ADD, MAXV, MINV, MAXV, MINV}, 1'b1, '{MAXV, MINV, 1'b1, 1'b0}},
    '{'{OP_ADD, MAXV, MINV, MINV, MAXV}, 1'b1, '{-1, -1, 1'b0, 1'b0}},
    '{'{OP_SUB, MINV, MAXV, 1, -1}, 1'b1, '{MINV, MAXV, 1'b1, 1'b0}},
    '{'{OP_SUB, 0, 0, MINV, MINV}, 1'b1, '{MAXV, MAXV, 1'b1, 1'b0}},
    '{'{OP_SUB, MAXV, MINV, MAXV, MINV}, 1'b1, '{0, 0, 1'b0, 1'b0}},
    '{'{OP_MUL, ONE, 0, ONE, 0}, 1'b1, '{ONE, 0, 1'b0, 1'b0}},
    '{'{OP_MUL, 0, ONE, 0, ONE}, 1'b1, '{-ONE, 0, 1'b0, 1'b0}},
    '{'{OP_MUL, MAXV, MAXV, MAXV, MAXV}, 1'b1, '{0, MAXV, 1'b1, 1'b0}},
    '{'{OP_MUL, MINV, MINV, MINV, MINV}, 1'b1, '{0, MAXV, 1'b1, 1'b0}},
    '{'{OP_MUL, -1, 0, 1, 0}, 1'b0, '0},
    '{'{OP_MUL, MINV, MAXV, MAXV, MINV}, 1'b0, '0},
    '{'{OP_DIV, ONE, ONE, 0, 0}, 1'b1, '{0, 0, 1'b0, 1'b1}},
    '{'{OP_DIV, MAXV, MINV, 0, 0}, 1'b1, '{0, 0, 1'b0, 1'b1}},
    '{'{OP_DIV, ONE, 0, ONE, 0}, 1'b1, '{ONE, 0, 1'b0, 1'b0}},
    '{'{OP_DIV, MAXV, MAXV, 1, 0}, 1'b1, '{MAXV, MAXV, 1'b1, 1'b0}},
    '{'{OP_DIV, MINV, MINV, 0, 1}, 1'b1, '{MINV, MAXV, 1'b1, 1'b0}},
    '{'{OP_DIV, MAXV, MINV, MINV, MAXV}, 1'b0, '0},
    '{'{OP_DIV, MINV, MINV, MINV, MINV}, 1'b0, '0},
    '{'{OP_DIV, -1, 1, 3, -7}, 1'b0, '0},
    '{'{OP_DIV, 0, 0, MAXV, 1}, 1'b1, '{0, 0, 1'b0, 1'b0}}
  };

  initial begin
    cau_req_t q;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (table_v[i]) send(table_v[i].req, table_v[i].has_res, table_v[i].res);
    for (int n = 0; n < N_RANDOM; n++) begin
      send_idle = (n < 180) ? 24 : (n < 360) ? 45 : 0;
      if (n == 270) begin
        start_i <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk_i);
      end
      q.op = cau_op_e'($urandom_range(0, 3));
      q.a_re = rand_part();
      q.a_im = rand_part();
      q.b_re = rand_part();
      q.b_im = rand_part();
      if (q.op == OP_DIV && $urandom_range(0, 9) == 0) begin
        q.b_re = '0;
        q.b_im = '0;
      end
      send(q, 1'b0, '0);
    end
    start_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
